### sv/ngga_pkg.sv
// Shared types, character codes and result codes for the GGA sentence parser.
`default_nettype none

package ngga_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_END     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [1:0] V_OK       = 2'd0;
    localparam logic [1:0] V_MISMATCH = 2'd1;
    localparam logic [1:0] V_BADHEX   = 2'd2;

    localparam logic [15:0] MASK_RESET = 16'd2046;
    localparam logic [3:0]  FIELD_MAX  = 4'd15;

    // Register index as decoded from the byte address.
    localparam logic REG_FIELD_MASK = 1'b0;
    localparam logic REG_LOWER_HEX  = 1'b1;

    typedef struct packed {
        logic [15:0] field_emit_mask;
        logic        accept_lowercase_hex;
    } t_cfg;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    // Decodes one checksum digit; lowercase letters count only when enabled.
    function automatic t_hex hex_digit(input logic [7:0] c, input logic lower_ok);
        t_hex h;
        h.ok  = 1'b0;
        h.nib = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h37);
        end else if (lower_ok && c >= 8'h61 && c <= 8'h66) begin
            h.ok  = 1'b1;
            h.nib = 4'(c - 8'h57);
        end
        return h;
    endfunction

endpackage

`default_nettype wire

### sv/ngga_cfg.sv
// APB-style configuration registers of the GGA sentence parser.
`default_nettype none

module ngga_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output ngga_pkg::t_cfg      o_cfg
);

    logic [15:0] r_mask;
    logic        r_lower;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= ngga_pkg::MASK_RESET;
            r_lower <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                ngga_pkg::REG_FIELD_MASK: r_mask  <= pwdata[15:0];
                ngga_pkg::REG_LOWER_HEX:  r_lower <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            ngga_pkg::REG_FIELD_MASK: prdata = {16'd0, r_mask};
            ngga_pkg::REG_LOWER_HEX:  prdata = {31'd0, r_lower};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg.field_emit_mask      = r_mask;
    assign o_cfg.accept_lowercase_hex = r_lower;

endmodule

`default_nettype wire

### sv/nmea_gga_sentence_parser.sv
// Top level of the streaming NMEA GGA sentence parser with XOR checksum check.
`default_nettype none

// The parser takes one received byte per transaction and answers with at most
// one result transaction per byte. It accepts a byte in every clock cycle:
// each byte is decoded combinationally against the sentence state and the
// result lands in an output register, so o_in_ready stays high as long as
// that register is empty or is being taken in the same cycle. A '$' restarts
// the sentence from any phase. Body bytes up to '*' are folded into the XOR
// checksum and split into numbered fields at each ','; characters of fields
// whose bit is set in field_emit_mask are reported, every ',' or '*' reports
// an end of field, and the second hex digit after '*' reports the verdict
// together with the computed checksum. Field numbers stop at 15. The verdict
// follows the fields, since the sentence is streamed. The user must write the
// registers over the APB-style port at byte address 0 (field_emit_mask) and 4
// (accept_lowercase_hex) only while no transaction is in flight (not enforced).

module nmea_gga_sentence_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Byte input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_rx_byte,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_result_kind,
    output logic [3:0]       o_field_number,
    output logic [7:0]       o_char_value,
    output logic [1:0]       o_verdict,
    output logic [7:0]       o_computed_sum
);

    // Sentence phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_BODY = 4'b0010,
        PH_HEX1 = 4'b0100,
        PH_HEX2 = 4'b1000
    } t_phase;

    ngga_pkg::t_cfg cfg;

    ngga_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sentence state.
    t_phase     r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [3:0] r_field, n_field;
    logic [3:0] r_high_nib, n_high_nib;
    logic       r_high_bad, n_high_bad;

    // Output register.
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [3:0] r_fnum;
    logic [7:0] r_char;
    logic [1:0] r_verd;
    logic [7:0] r_sum;

    // Result of the byte being accepted in this cycle.
    logic       emit;
    logic [1:0] n_kind;
    logic [3:0] n_fnum;
    logic [7:0] n_char;
    logic [1:0] n_verd;
    logic [7:0] n_sum;

    logic           accept;
    ngga_pkg::t_hex hex;

    // The output register frees up in the same cycle its result is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign hex        = ngga_pkg::hex_digit(i_rx_byte, cfg.accept_lowercase_hex);

    always_comb begin
        n_phase    = r_phase;
        n_xor      = r_xor;
        n_field    = r_field;
        n_high_nib = r_high_nib;
        n_high_bad = r_high_bad;
        emit       = 1'b0;
        n_kind     = ngga_pkg::KIND_CHAR;
        n_fnum     = r_field;
        n_char     = 8'd0;
        n_verd     = ngga_pkg::V_OK;
        n_sum      = 8'd0;

        if (i_rx_byte == ngga_pkg::CH_DOLLAR) begin
            // A dollar restarts the sentence and drops any pending verdict.
            n_phase    = PH_BODY;
            n_xor      = 8'd0;
            n_field    = 4'd0;
            n_high_nib = 4'd0;
            n_high_bad = 1'b0;
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_BODY: begin
                    if (i_rx_byte == ngga_pkg::CH_STAR) begin
                        emit    = 1'b1;
                        n_kind  = ngga_pkg::KIND_END;
                        n_phase = PH_HEX1;
                    end else begin
                        n_xor = r_xor ^ i_rx_byte;
                        if (i_rx_byte == ngga_pkg::CH_COMMA) begin
                            emit   = 1'b1;
                            n_kind = ngga_pkg::KIND_END;
                            if (r_field != ngga_pkg::FIELD_MAX) begin
                                n_field = r_field + 4'd1;
                            end
                        end else if (cfg.field_emit_mask[r_field]) begin
                            emit   = 1'b1;
                            n_kind = ngga_pkg::KIND_CHAR;
                            n_char = i_rx_byte;
                        end
                    end
                end
                PH_HEX1: begin
                    n_high_nib = hex.nib;
                    n_high_bad = !hex.ok;
                    n_phase    = PH_HEX2;
                end
                PH_HEX2: begin
                    emit    = 1'b1;
                    n_kind  = ngga_pkg::KIND_VERDICT;
                    n_sum   = r_xor;
                    n_phase = PH_IDLE;
                    if (!hex.ok || r_high_bad) begin
                        n_verd = ngga_pkg::V_BADHEX;
                    end else if ({r_high_nib, hex.nib} == r_xor) begin
                        n_verd = ngga_pkg::V_OK;
                    end else begin
                        n_verd = ngga_pkg::V_MISMATCH;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_xor       <= 8'd0;
            r_field     <= 4'd0;
            r_high_nib  <= 4'd0;
            r_high_bad  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase     <= n_phase;
                r_xor       <= n_xor;
                r_field     <= n_field;
                r_high_nib  <= n_high_nib;
                r_high_bad  <= n_high_bad;
                r_out_valid <= emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers load only with a new result.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_kind <= n_kind;
            r_fnum <= n_fnum;
            r_char <= n_char;
            r_verd <= n_verd;
            r_sum  <= n_sum;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_kind  = r_kind;
    assign o_field_number = r_fnum;
    assign o_char_value   = r_char;
    assign o_verdict      = r_verd;
    assign o_computed_sum = r_sum;

    // A dollar always opens a fresh sentence body with a cleared checksum.
    a_dollar_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rx_byte == ngga_pkg::CH_DOLLAR)
        |=> (r_phase == PH_BODY && r_xor == 8'd0 && r_field == 4'd0))
        else $error("dollar did not restart the sentence");

    // The second checksum digit always produces a verdict.
    a_hex2_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_phase == PH_HEX2 && i_rx_byte != ngga_pkg::CH_DOLLAR)
        |=> (o_out_valid && o_result_kind == ngga_pkg::KIND_VERDICT))
        else $error("second checksum digit gave no verdict");

    // Character and field-end results carry no verdict and no checksum.
    a_nonverdict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != ngga_pkg::KIND_VERDICT)
        |-> (o_verdict == ngga_pkg::V_OK && o_computed_sum == 8'd0))
        else $error("non-verdict result carries verdict data");

    // An empty output register never blocks the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule

`default_nettype wire
